FILE: hw/rtl/lfys_pkg.sv
// lfys_pkg: shared constants and types of the lcg fisher-yates shuffle block
// generator constants, register map, divider step count and controller states
// no dependencies
package lfys_pkg;

    // default list capacity
    localparam int MAX_ITEMS_DEF = 64;

    // linear congruential generator
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;
    localparam int          LCG_TAKE_SHIFT = 16;

    // swap partner is taken from 16 generator bits, one dividend bit per cycle
    localparam int DIV_STEPS = 32 - LCG_TAKE_SHIFT;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // configuration port
    localparam int          ADDR_W         = 2;
    localparam logic [ADDR_W-1:0] REG_START_SEED = 2'd0;

    // controller states
    typedef enum logic [3:0] {
        S_LOAD,
        S_LCG,
        S_DIV,
        S_RD_I,
        S_RD_J,
        S_WR_I,
        S_WR_J,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_HOLD
    } t_state;

endpackage

FILE: hw/rtl/lfys_if.sv
// lfys_if: valid/ready channel interfaces for list input words and shuffled output words
// depends on nothing but the fixed field widths

// input channel: one list element per word
interface lfys_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] element_value;
    logic        is_last;

    modport source (output valid, output element_value, output is_last, input ready);
    modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

// output channel: one shuffled element per word
interface lfys_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] shuffled_value;
    logic        is_final;
    logic [31:0] end_seed;

    modport source (output valid, output shuffled_value, output is_final, output end_seed,
                    input ready);
    modport sink   (input valid, input shuffled_value, input is_final, input end_seed,
                    output ready);
endinterface

FILE: hw/rtl/lfys_ram.sv
// lfys_ram: generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
module lfys_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lcg_fisher_yates_shuffle.sv
// lcg_fisher_yates_shuffle: top level, list load, lcg-driven in-place shuffle, emission
// depends on lfys_pkg, lfys_if (lfys_in_if, lfys_out_if) and lfys_ram
//
// Usage
//   i_in carries list elements, one word per element, in list order; the word with
//   is_last set closes the list and starts the shuffle. Up to MAX_ITEMS elements are
//   kept, further ones are dropped (a dropped word marked last still starts the shuffle).
//   o_out then returns the permuted list, one word per element; the last word has
//   is_final set and end_seed holds the generator value after the shuffle. The user
//   writes start_seed at apb address 0 only while idle; the block does not enforce it.
// Operation
//   Loading takes one word per cycle. The shuffle runs one position at a time through
//   the element ram: the generator multiply, the bit-serial remainder by position+1,
//   and the ram traffic for the swap (read i, read j, write i, write j). Emission reads
//   each word from the ram, captures it and hands it over. i_in.ready is low from the
//   last word of a list until the final output word is taken.
// Reset and stall
//   Reset clears the element count, the generator and start_seed; the ram needs no
//   clearing since only entries of the current list are read. A stalled receiver holds
//   the output word in its register and the block waits.
module lcg_fisher_yates_shuffle
    import lfys_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lfys_in_if.sink           i_in,
    lfys_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int RW = CW + 1;

    t_state r_state, n_state;

    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_n, n_n;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_j, n_j;
    logic [AW-1:0]     r_k, n_k;
    logic [31:0]       r_seed, n_seed;
    logic [31:0]       r_start_seed;
    logic [15:0]       r_dividend, n_dividend;
    logic [RW-1:0]     r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    logic [15:0]       r_di, n_di;
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_out_value, n_out_value;
    logic              r_out_final, n_out_final;
    logic [31:0]       r_out_seed, n_out_seed;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // helpers
    logic          in_fire;
    logic          out_fire;
    logic [CW-1:0] cnt_sat;
    logic [CW-1:0] last_pos;
    logic [RW-1:0] divisor;
    logic [RW-1:0] shifted;
    logic [CW-1:0] k_next;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_out_valid && o_out.ready;
    assign cnt_sat  = (r_count < CW'(MAX_ITEMS)) ? (r_count + CW'(1)) : r_count;
    assign last_pos = cnt_sat - CW'(1);
    assign divisor  = RW'(r_pos) + RW'(1);
    assign shifted  = {r_rem[RW-2:0], r_dividend[15]};
    assign k_next   = CW'(r_k) + CW'(1);

    // element store
    lfys_ram #(
        .WIDTH (16),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seed <= '0;
        end else if (psel && penable && pwrite && (paddr == REG_START_SEED)) begin
            r_start_seed <= pwdata;
        end
    end

    assign prdata = (paddr == REG_START_SEED) ? r_start_seed : '0;
    assign pready = 1'b1;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_seed      <= n_seed;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_pos       <= n_pos;
        r_j         <= n_j;
        r_k         <= n_k;
        r_dividend  <= n_dividend;
        r_rem       <= n_rem;
        r_step      <= n_step;
        r_di        <= n_di;
        r_out_value <= n_out_value;
        r_out_final <= n_out_final;
        r_out_seed  <= n_out_seed;
    end

    // next state, datapath and ram control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_n         = r_n;
        n_pos       = r_pos;
        n_j         = r_j;
        n_k         = r_k;
        n_seed      = r_seed;
        n_dividend  = r_dividend;
        n_rem       = r_rem;
        n_step      = r_step;
        n_di        = r_di;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_final = r_out_final;
        n_out_seed  = r_out_seed;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_pos;

        case (r_state)
            // store incoming words, start the shuffle on the last one
            S_LOAD: begin
                if (in_fire) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[AW-1:0];
                        ram_wdata = i_in.element_value;
                    end
                    n_count = cnt_sat;
                    if (i_in.is_last) begin
                        n_count = '0;
                        n_n     = cnt_sat;
                        n_pos   = last_pos[AW-1:0];
                        n_seed  = r_start_seed;
                        n_k     = '0;
                        n_state = (cnt_sat == CW'(1)) ? S_EMIT_RD : S_LCG;
                    end
                end
            end
            // advance the generator and load the remainder unit
            S_LCG: begin
                n_seed     = r_seed * LCG_MUL + LCG_ADD;
                n_dividend = n_seed[31:LCG_TAKE_SHIFT];
                n_rem      = '0;
                n_step     = '0;
                n_state    = S_DIV;
            end
            // restoring remainder, one dividend bit per cycle
            S_DIV: begin
                n_rem      = (shifted >= divisor) ? (shifted - divisor) : shifted;
                n_dividend = {r_dividend[14:0], 1'b0};
                n_step     = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_RD_I;
                end
            end
            // swap: read i, read j, write i, write j
            S_RD_I: begin
                n_j       = r_rem[AW-1:0];
                ram_raddr = r_pos;
                n_state   = S_RD_J;
            end
            S_RD_J: begin
                ram_raddr = r_j;
                n_di      = ram_rdata;
                n_state   = S_WR_I;
            end
            S_WR_I: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = ram_rdata;
                n_state   = S_WR_J;
            end
            S_WR_J: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_di;
                n_pos     = r_pos - AW'(1);
                n_state   = (r_pos == AW'(1)) ? S_EMIT_RD : S_LCG;
            end
            // emission, one element at a time
            S_EMIT_RD: begin
                ram_raddr = r_k;
                n_state   = S_EMIT_CAP;
            end
            S_EMIT_CAP: begin
                n_out_valid = 1'b1;
                n_out_value = ram_rdata;
                n_out_final = (k_next == r_n);
                n_out_seed  = (k_next == r_n) ? r_seed : '0;
                n_state     = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (out_fire) begin
                    n_out_valid = 1'b0;
                    if (r_out_final) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // channel outputs
    assign i_in.ready           = (r_state == S_LOAD);
    assign o_out.valid          = r_out_valid;
    assign o_out.shuffled_value = r_out_value;
    assign o_out.is_final       = r_out_final;
    assign o_out.end_seed       = r_out_seed;

endmodule

FILE: verif/lcg_fisher_yates_shuffle_tb.sv
// lcg_fisher_yates_shuffle_tb: self-checking bench for the lcg fisher-yates shuffle block
// predicts every shuffled word from its own copy of the list store and generator
// depends on lfys_pkg, lfys_if (lfys_in_if, lfys_out_if) and lcg_fisher_yates_shuffle
module lcg_fisher_yates_shuffle_tb;
    import lfys_pkg::*;

    localparam int CAPACITY     = MAX_ITEMS_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;

    // one list element as sent
    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } t_list_word;

    // one shuffled element as expected back
    typedef struct packed {
        logic [15:0] value;
        logic        fin;
        logic [31:0] seed;
    } t_shuffled_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    lfys_in_if  in_ch ();
    lfys_out_if out_ch ();

    lcg_fisher_yates_shuffle u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pending list words and expected shuffled words
    t_list_word     load_q[$];
    t_shuffled_word shuffled_q[$];

    // predictor state
    logic [15:0] list_mem [CAPACITY];
    int          held_count = 0;
    logic [31:0] gen_seed = 32'd0;
    logic [31:0] cfg_start_seed;

    int             send_idle_pct;
    int             recv_idle_pct;
    int             mismatch_count = 0;
    int             cycle_count = 0;
    t_list_word     drv_word;
    t_shuffled_word mon_word;

    // clock, period 4
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // store one element; a last word shuffles the held list and queues the permutation
    task automatic shuffle_predict(input logic [15:0] value, input logic last);
        int n;
        int j;
        logic [15:0] tmp;
        t_shuffled_word w;
        if (held_count < CAPACITY) begin
            list_mem[held_count] = value;
            held_count++;
        end
        if (last) begin
            n = held_count;
            gen_seed = cfg_start_seed;
            for (int i = n - 1; i > 0; i--) begin
                gen_seed = gen_seed * LCG_MUL + LCG_ADD;
                j = int'(gen_seed[31:LCG_TAKE_SHIFT]) % (i + 1);
                tmp = list_mem[i];
                list_mem[i] = list_mem[j];
                list_mem[j] = tmp;
            end
            for (int k = 0; k < n; k++) begin
                w.value = list_mem[k];
                w.fin   = (k == n - 1);
                w.seed  = w.fin ? gen_seed : 32'd0;
                shuffled_q.push_back(w);
            end
            held_count = 0;
        end
    endtask

    // queue one list of len words, the final one marked last
    task automatic push_list(input int len);
        t_list_word w;
        for (int k = 0; k < len; k++) begin
            w.value = 16'($urandom);
            w.last  = (k == len - 1);
            load_q.push_back(w);
        end
    endtask

    task automatic push_word(input logic [15:0] value, input logic last);
        t_list_word w;
        w.value = value;
        w.last  = last;
        load_q.push_back(w);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_start_seed(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_START_SEED;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_start_seed = value;
    endtask

    // wait until every word is sent and every expected word is back, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (load_q.size() != 0 || in_ch.valid || shuffled_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                shuffle_predict(in_ch.element_value, in_ch.is_last);
            if (!in_ch.valid || in_ch.ready) begin
                if (load_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_word = load_q.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.element_value <= drv_word.value;
                    in_ch.is_last       <= drv_word.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (shuffled_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got value %h final %b seed %h",
                         $time, out_ch.shuffled_value, out_ch.is_final, out_ch.end_seed);
                mismatch_count++;
            end else begin
                mon_word = shuffled_q.pop_front();
                if (out_ch.shuffled_value !== mon_word.value) begin
                    $display("%0t: shuffled_value expected %h got %h",
                             $time, mon_word.value, out_ch.shuffled_value);
                    mismatch_count++;
                end
                if (out_ch.is_final !== mon_word.fin) begin
                    $display("%0t: is_final expected %b got %b",
                             $time, mon_word.fin, out_ch.is_final);
                    mismatch_count++;
                end
                if (out_ch.end_seed !== mon_word.seed) begin
                    $display("%0t: end_seed expected %h got %h",
                             $time, mon_word.seed, out_ch.end_seed);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words still expected", $time, shuffled_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus
    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = REG_START_SEED;
        pwdata              = 32'd0;
        cfg_start_seed      = 32'd0;
        send_idle_pct       = 26;
        recv_idle_pct       = 56;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset seed, single-element list, two-element list, field extremes
        push_word(16'hFFFF, 1'b1);
        push_word(16'h0000, 1'b0);
        push_word(16'hFFFF, 1'b1);
        push_word(16'hAAAA, 1'b0);
        push_word(16'h5555, 1'b0);
        push_word(16'h0001, 1'b0);
        push_word(16'h8000, 1'b1);
        wait_drained();

        // directed: all-ones seed, single element again, short ascending list
        write_start_seed(32'hFFFF_FFFF);
        push_word(16'h1234, 1'b1);
        for (int k = 1; k <= 5; k++)
            push_word(16'(k), k == 5);
        wait_drained();

        // directed: seed one, eight-element list
        write_start_seed(32'h0000_0001);
        for (int k = 0; k < 8; k++)
            push_word(16'(k * 16'h1111), k == 7);
        wait_drained();

        // random lists; one phase fills the store exactly, one overflows it
        for (int ph = 3; ph <= 8; ph++) begin
            if (ph < 5) begin
                send_idle_pct = 26;
                recv_idle_pct = 56;
            end else if (ph < 7) begin
                send_idle_pct = 56;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                4: write_start_seed(32'hFFFF_FFFF);
                6: write_start_seed(32'h0000_0000);
                8: write_start_seed(32'h7FFF_FFFF);
                default: write_start_seed($urandom);
            endcase
            if (ph == 4) begin
                push_list(CAPACITY);
            end else if (ph == 7) begin
                // dropped words past capacity, the dropped last one still starts the shuffle
                push_list(CAPACITY + 3);
            end else begin
                for (int cnt = 0; cnt < 4; ) begin
                    int len;
                    len = $urandom_range(1, 8);
                    push_list(len);
                    cnt += len;
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0 && shuffled_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
